@@ src/sprite_quad_vertex_expander_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Sprite quad vertex expander assertion macros
// Concurrent assertion shorthands on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SPRITE_QUAD_VERTEX_EXPANDER_UNIT_ASSERT_SVH
`define SPRITE_QUAD_VERTEX_EXPANDER_UNIT_ASSERT_SVH

// a in the same cycle implies b
`define SQVE_ASSERT_SAME(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("sqve assertion failed");

// a implies b in the next cycle
`define SQVE_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("sqve assertion failed");

`endif

@@ src/sqve_pkg.sv @@
// ----------------------------------------------------------------------------
// Sprite quad vertex expander package
// Widths, descriptor types, corner tables and grid arithmetic helpers.
// ----------------------------------------------------------------------------
package sqve_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DIR_FRAC  = 14;
  localparam int SIZE_W    = 31;
  localparam int HALF_W    = 16;
  localparam int DIR_W     = 16;
  localparam int BORD_W    = HALF_W + FRAC_BITS;
  localparam int LOC_W     = ((SIZE_W > BORD_W) ? SIZE_W : BORD_W) + 2;
  localparam int PROD_W    = LOC_W + DIR_W;
  localparam int SUM_W     = PROD_W + 1;
  localparam int SH_W      = SUM_W - DIR_FRAC;
  localparam int POS_W     = SH_W + 1;
  localparam int TEX_W     = 17;
  localparam int TS_W      = HALF_W + 3;
  localparam int IDX_W     = 6;

  localparam logic [IDX_W-1:0] PLAIN_LAST = IDX_W'(5);
  localparam logic [IDX_W-1:0] NINE_LAST  = IDX_W'(53);
  localparam logic [2:0]       STEP_LAST  = 3'd5;
  localparam logic [1:0]       CELL_LAST  = 2'd2;

  // corner steps, bit s is step s
  localparam logic [5:0] STEP_X = 6'b010110;
  localparam logic [5:0] STEP_Y = 6'b110100;

  localparam logic [TEX_W-1:0] TEX_MAX = {TEX_W{1'b1}};
  localparam logic signed [SUM_W-1:0] RND = SUM_W'(1) << (DIR_FRAC - 1);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic signed [31:0]  pos_x;
    logic signed [31:0]  pos_y;
    logic [31:0]         pos_z;
    logic [SIZE_W-1:0]   size_w;
    logic [SIZE_W-1:0]   size_h;
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic [HALF_W-1:0]   org_u;
    logic [HALF_W-1:0]   org_v;
    logic [HALF_W-1:0]   ext_u;
    logic [HALF_W-1:0]   ext_v;
    logic [HALF_W-1:0]   bor_u;
    logic [HALF_W-1:0]   bor_v;
    logic [31:0]         color;
    logic                nine;
    logic [IDX_W-1:0]    last_idx;
  } desc_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [31:0]        pos_z;
    logic [TEX_W-1:0]   tex_u;
    logic [TEX_W-1:0]   tex_v;
    logic [31:0]        color;
    logic [IDX_W-1:0]   idx;
    logic               last;
  } pass_t;

  // c*full + (d-c)*border in position units
  function automatic logic signed [LOC_W-1:0] grid_off(logic [1:0] g,
                                                      logic [SIZE_W-1:0] full,
                                                      logic [HALF_W-1:0] bord);
    logic signed [LOC_W-1:0] f;
    logic signed [LOC_W-1:0] b;
    logic signed [LOC_W-1:0] r;
    f = $signed({{(LOC_W-SIZE_W){1'b0}}, full});
    b = $signed({{(LOC_W-BORD_W){1'b0}}, bord, {FRAC_BITS{1'b0}}});
    case (g)
      2'd0:    r = '0;
      2'd1:    r = b;
      2'd2:    r = f - b;
      default: r = f;
    endcase
    return r;
  endfunction

  // texture coordinate with clamp to 0..TEX_MAX
  function automatic logic [TEX_W-1:0] tex_coord(logic [HALF_W-1:0] org,
                                                 logic [1:0] g,
                                                 logic [HALF_W-1:0] ext,
                                                 logic [HALF_W-1:0] bord);
    logic signed [TS_W-1:0] o;
    logic signed [TS_W-1:0] e;
    logic signed [TS_W-1:0] b;
    logic signed [TS_W-1:0] t;
    logic [TEX_W-1:0] r;
    o = $signed({3'b000, org});
    e = $signed({3'b000, ext});
    b = $signed({3'b000, bord});
    case (g)
      2'd0:    t = o;
      2'd1:    t = o + b;
      2'd2:    t = o + e - b;
      default: t = o + e;
    endcase
    if (t < 0) begin
      r = '0;
    end else if (t > $signed({2'b00, TEX_MAX})) begin
      r = TEX_MAX;
    end else begin
      r = t[TEX_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] sat32(logic signed [POS_W-1:0] v);
    logic [31:0] r;
    if (v > $signed({{(POS_W-32){1'b0}}, 32'h7FFF_FFFF})) begin
      r = 32'h7FFF_FFFF;
    end else if (v < $signed({{(POS_W-32){1'b1}}, 32'h8000_0000})) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ src/sqve_front.sv @@
// ----------------------------------------------------------------------------
// Sprite quad vertex expander front end
// Accepts sprite items, splits packed fields, tags each with its last index.
// ----------------------------------------------------------------------------
module sqve_front (
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [31:0]            in_pos_x,
  input  logic signed [31:0]            in_pos_y,
  input  logic signed [31:0]            in_pos_z,
  input  logic [sqve_pkg::SIZE_W-1:0]   in_size_w,
  input  logic [sqve_pkg::SIZE_W-1:0]   in_size_h,
  input  logic signed [sqve_pkg::DIR_W-1:0] in_dir_x,
  input  logic signed [sqve_pkg::DIR_W-1:0] in_dir_y,
  input  logic [31:0]                   in_tex_origin,
  input  logic [31:0]                   in_tex_extent,
  input  logic [31:0]                   in_border,
  input  logic [31:0]                   in_color_rgba,
  input  logic                          nine_mode,
  input  logic                          q_full,
  output logic                          q_push,
  output sqve_pkg::desc_t               q_desc
);

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_desc          = '0;
    q_desc.pos_x    = in_pos_x;
    q_desc.pos_y    = in_pos_y;
    q_desc.pos_z    = in_pos_z;
    q_desc.size_w   = in_size_w;
    q_desc.size_h   = in_size_h;
    q_desc.dir_x    = in_dir_x;
    q_desc.dir_y    = in_dir_y;
    q_desc.org_u    = in_tex_origin[15:0];
    q_desc.org_v    = in_tex_origin[31:16];
    q_desc.ext_u    = in_tex_extent[15:0];
    q_desc.ext_v    = in_tex_extent[31:16];
    q_desc.bor_u    = in_border[15:0];
    q_desc.bor_v    = in_border[31:16];
    q_desc.color    = in_color_rgba;
    q_desc.nine     = nine_mode;
    q_desc.last_idx = nine_mode ? sqve_pkg::NINE_LAST : sqve_pkg::PLAIN_LAST;
  end

endmodule

@@ src/sqve_queue.sv @@
// ----------------------------------------------------------------------------
// Sprite quad vertex expander descriptor queue
// Short FIFO of sprite descriptors between the front and back ends.
// ----------------------------------------------------------------------------
module sqve_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  sqve_pkg::desc_t      push_desc,
  input  logic                 pop,
  output logic                 full,
  output logic                 head_valid,
  output sqve_pkg::desc_t      head_desc
);

  sqve_pkg::desc_t                 entry_r [sqve_pkg::QDEPTH];
  logic [sqve_pkg::QPTR_W-1:0]     wr_ptr_r;
  logic [sqve_pkg::QPTR_W-1:0]     rd_ptr_r;
  logic [sqve_pkg::QCNT_W-1:0]     cnt_r;

  assign full       = (cnt_r == sqve_pkg::QCNT_W'(sqve_pkg::QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_desc  = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

@@ src/sqve_back.sv @@
// ----------------------------------------------------------------------------
// Sprite quad vertex expander back end
// Walks the head sprite's corners and computes one vertex per cycle unless
// stalled; four-stage pipeline: offsets, products, round, place and saturate.
// ----------------------------------------------------------------------------
module sqve_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  sqve_pkg::desc_t               q_desc,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [31:0]            out_vert_x,
  output logic signed [31:0]            out_vert_y,
  output logic signed [31:0]            out_vert_z,
  output logic [sqve_pkg::TEX_W-1:0]    out_tex_u,
  output logic [sqve_pkg::TEX_W-1:0]    out_tex_v,
  output logic [31:0]                   out_color_out,
  output logic [sqve_pkg::IDX_W-1:0]    out_vertex_index,
  output logic                          out_last
);

  logic                         adv;
  logic                         issue;
  logic [sqve_pkg::IDX_W-1:0]   k_r;
  logic [2:0]                   s_r;
  logic [1:0]                   cx_r;
  logic [1:0]                   cy_r;
  logic [1:0]                   gx;
  logic [1:0]                   gy;
  logic                         stx;
  logic                         sty;

  logic                         v1_r, v2_r, v3_r, v4_r;
  sqve_pkg::pass_t              pass_nxt;
  sqve_pkg::pass_t              p1_r, p2_r, p3_r;
  logic signed [sqve_pkg::LOC_W-1:0]  lx_r, ly_r;
  logic signed [sqve_pkg::DIR_W-1:0]  dx_r, dy_r;
  logic signed [sqve_pkg::PROD_W-1:0] xdy_r, ydx_r, xdx_r, ydy_r;
  logic signed [sqve_pkg::SUM_W-1:0]  sx_r, sy_r;
  logic signed [sqve_pkg::SH_W-1:0]   shx, shy;
  logic signed [sqve_pkg::POS_W-1:0]  wx, wy;

  assign adv   = !v4_r || !out_stall;
  assign issue = adv && q_valid;
  assign q_pop = issue && (k_r == q_desc.last_idx);

  // corner walk
  always_comb begin
    stx = sqve_pkg::STEP_X[s_r];
    sty = sqve_pkg::STEP_Y[s_r];
    if (q_desc.nine) begin
      gx = cx_r + {1'b0, stx};
      gy = cy_r + {1'b0, sty};
    end else begin
      gx = {stx, stx};
      gy = {sty, sty};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r  <= '0;
      s_r  <= '0;
      cx_r <= '0;
      cy_r <= '0;
    end else if (issue) begin
      if (q_pop) begin
        k_r  <= '0;
        s_r  <= '0;
        cx_r <= '0;
        cy_r <= '0;
      end else begin
        k_r <= k_r + 1'b1;
        if (s_r == sqve_pkg::STEP_LAST) begin
          s_r <= '0;
          if (cy_r == sqve_pkg::CELL_LAST) begin
            cy_r <= '0;
            cx_r <= cx_r + 1'b1;
          end else begin
            cy_r <= cy_r + 1'b1;
          end
        end else begin
          s_r <= s_r + 1'b1;
        end
      end
    end
  end

  always_comb begin
    pass_nxt       = '0;
    pass_nxt.pos_x = q_desc.pos_x;
    pass_nxt.pos_y = q_desc.pos_y;
    pass_nxt.pos_z = q_desc.pos_z;
    pass_nxt.tex_u = sqve_pkg::tex_coord(q_desc.org_u, gx, q_desc.ext_u, q_desc.bor_u);
    pass_nxt.tex_v = sqve_pkg::tex_coord(q_desc.org_v, gy, q_desc.ext_v, q_desc.bor_v);
    pass_nxt.color = q_desc.color;
    pass_nxt.idx   = k_r;
    pass_nxt.last  = (k_r == q_desc.last_idx);
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= q_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  assign shx = sx_r[sqve_pkg::SUM_W-1:sqve_pkg::DIR_FRAC];
  assign shy = sy_r[sqve_pkg::SUM_W-1:sqve_pkg::DIR_FRAC];
  assign wx  = $signed({{(sqve_pkg::POS_W-32){p3_r.pos_x[31]}}, p3_r.pos_x})
             + $signed({shx[sqve_pkg::SH_W-1], shx});
  assign wy  = $signed({{(sqve_pkg::POS_W-32){p3_r.pos_y[31]}}, p3_r.pos_y})
             + $signed({shy[sqve_pkg::SH_W-1], shy});

  // datapath
  always_ff @(posedge clk) begin
    if (adv) begin
      p1_r <= pass_nxt;
      lx_r <= sqve_pkg::grid_off(gx, q_desc.size_w, q_desc.bor_u);
      ly_r <= sqve_pkg::grid_off(gy, q_desc.size_h, q_desc.bor_v);
      dx_r <= q_desc.dir_x;
      dy_r <= q_desc.dir_y;

      p2_r  <= p1_r;
      xdy_r <= lx_r * dy_r;
      ydx_r <= ly_r * dx_r;
      xdx_r <= lx_r * dx_r;
      ydy_r <= ly_r * dy_r;

      p3_r <= p2_r;
      sx_r <= $signed({xdy_r[sqve_pkg::PROD_W-1], xdy_r})
            + $signed({ydx_r[sqve_pkg::PROD_W-1], ydx_r}) + sqve_pkg::RND;
      sy_r <= $signed({ydy_r[sqve_pkg::PROD_W-1], ydy_r})
            - $signed({xdx_r[sqve_pkg::PROD_W-1], xdx_r}) + sqve_pkg::RND;

      out_vert_x       <= sqve_pkg::sat32(wx);
      out_vert_y       <= sqve_pkg::sat32(wy);
      out_vert_z       <= p3_r.pos_z;
      out_tex_u        <= p3_r.tex_u;
      out_tex_v        <= p3_r.tex_v;
      out_color_out    <= p3_r.color;
      out_vertex_index <= p3_r.idx;
      out_last         <= p3_r.last;
    end
  end

  assign out_valid = v4_r;

endmodule

@@ src/sprite_quad_vertex_expander_unit.sv @@
// ----------------------------------------------------------------------------
// Sprite quad vertex expander
// Expands sprites into plain-quad or nine-slice triangle vertices.
// ----------------------------------------------------------------------------
// Each sprite item yields 6 vertices (plain) or 54 vertices (nine-slice),
// delivered one per cycle while the output is not stalled; vertices of the
// next sprite follow without a gap. The first vertex passes the offset,
// product, round and output registers after the sprite reaches the head of
// the two-entry descriptor queue. Items are taken while the queue has room,
// also while a vertex waits at the output. The mode is sampled per item at
// acceptance. Register 0 (byte address 0): bit 0 nine-slice mode, reset 0.
module sprite_quad_vertex_expander_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [31:0]            in_pos_x,
  input  logic signed [31:0]            in_pos_y,
  input  logic signed [31:0]            in_pos_z,
  input  logic [30:0]                   in_size_w,
  input  logic [30:0]                   in_size_h,
  input  logic signed [15:0]            in_dir_x,
  input  logic signed [15:0]            in_dir_y,
  input  logic [31:0]                   in_tex_origin,
  input  logic [31:0]                   in_tex_extent,
  input  logic [31:0]                   in_border,
  input  logic [31:0]                   in_color_rgba,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [31:0]            out_vert_x,
  output logic signed [31:0]            out_vert_y,
  output logic signed [31:0]            out_vert_z,
  output logic [16:0]                   out_tex_u,
  output logic [16:0]                   out_tex_v,
  output logic [31:0]                   out_color_out,
  output logic [5:0]                    out_vertex_index,
  output logic                          out_last
);

`include "sprite_quad_vertex_expander_unit_assert.svh"

  logic             nine_mode_r;
  logic             q_full;
  logic             q_push;
  logic             q_pop;
  logic             q_valid;
  logic             idx_at_end;
  sqve_pkg::desc_t  push_desc;
  sqve_pkg::desc_t  head_desc;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {31'b0, nine_mode_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nine_mode_r <= 1'b0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      nine_mode_r <= pwdata[0];
    end
  end

  sqve_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_pos_z      (in_pos_z),
    .in_size_w     (in_size_w),
    .in_size_h     (in_size_h),
    .in_dir_x      (in_dir_x),
    .in_dir_y      (in_dir_y),
    .in_tex_origin (in_tex_origin),
    .in_tex_extent (in_tex_extent),
    .in_border     (in_border),
    .in_color_rgba (in_color_rgba),
    .nine_mode     (nine_mode_r),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_desc        (push_desc)
  );

  sqve_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_desc  (push_desc),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_valid),
    .head_desc  (head_desc)
  );

  sqve_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_desc           (head_desc),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_vert_x       (out_vert_x),
    .out_vert_y       (out_vert_y),
    .out_vert_z       (out_vert_z),
    .out_tex_u        (out_tex_u),
    .out_tex_v        (out_tex_v),
    .out_color_out    (out_color_out),
    .out_vertex_index (out_vertex_index),
    .out_last         (out_last)
  );

  assign idx_at_end = (out_vertex_index == sqve_pkg::PLAIN_LAST) ||
                      (out_vertex_index == sqve_pkg::NINE_LAST);

  `SQVE_ASSERT_SAME(a_last_idx, out_valid && out_last, idx_at_end)
  `SQVE_ASSERT_SAME(a_idx_range, out_valid && !out_last, out_vertex_index != sqve_pkg::NINE_LAST)
  `SQVE_ASSERT_NEXT(a_push_seen, q_push, q_valid)
  `SQVE_ASSERT_SAME(a_pop_valid, q_pop, q_valid)

endmodule
